/* rtl/core/eod_pkg.sv */
// ----------------------------------------------------------------------------
// eod_pkg: shared types and constants of the ellipsoid overlap depth block
// Holds the datapath operation codes, the controller/datapath command and
// status groups, the golden-section constants and the register defaults.
// ----------------------------------------------------------------------------
package eod_pkg;

   // Widths of the fixed-point quantities.
   localparam int unsigned POS_W  = 34;   // heights, search bounds and points
   localparam int unsigned TOL_W  = 17;
   localparam int unsigned ITER_W = 7;

   // Golden ratio constants, (phi - 1) and (2 - phi) scaled by 2^32.
   localparam logic [31:0] GOLD_Q32   = 32'd2654435769;
   localparam logic [31:0] GOLD_C_Q32 = 32'd1640531527;

   // Register defaults after reset.
   localparam logic [TOL_W-1:0]  TOL_RESET  = 17'd66;
   localparam logic [ITER_W-1:0] ITER_RESET = 7'd25;

   // Register indexes of the configuration port.
   localparam logic CSR_TOL  = 1'b0;
   localparam logic CSR_ITER = 1'b1;

   // Operations that the controller asks of the datapath.
   typedef enum logic [4:0] {
      OP_NOP,
      OP_LOAD,
      OP_MX,
      OP_MZ,
      OP_MY,
      OP_MD,
      OP_SQH_GO,
      OP_H_END,
      OP_GMUL,
      OP_GADD,
      OP_EV_SET,
      OP_HW_T,
      OP_HW_BB,
      OP_HW_TT,
      OP_HW_SQ,
      OP_HW_AS,
      OP_HW_DIV,
      OP_HW_ACC,
      OP_STORE,
      OP_MOVE,
      OP_FINAL_S,
      OP_FINAL_H,
      OP_ZERO
   } op_type;

   typedef enum logic {
      UNIT_SQRT,
      UNIT_DIV
   } unit_mode_type;

   typedef struct packed {
      op_type op;
      logic   sel_v;   // work on the upper golden point rather than the lower
      logic   hide;    // line-versus-ellipse case
      logic   ek;      // ellipsoid whose half-width is being formed
   } cmd_type;

   typedef struct packed {
      logic far;         // bounding spheres are apart
      logic up;          // index of the upper ellipsoid
      logic hide_up;     // upper ellipsoid hides its lower half
      logic dy_gt;       // line lies outside the lower ellipse
      logic span_empty;  // no shared height span
      logic hw_zero;     // evaluation height is outside the ellipse
      logic unit_done;   // iterative unit has finished
      logic ft_lt_fv;    // lower point value below upper point value
      logic stop;        // search has converged or hit its cap
   } status_type;

endpackage

/* rtl/core/ellipsoid_overlap_depth.sv */
// ----------------------------------------------------------------------------
// ellipsoid_overlap_depth: horizontal overlap of two ellipsoids
//
//   Channel    Ports                      Transfer
//   item in    start, busy, req_*         start high while busy low
//   result     rsp_strobe, rsp_*          one cycle, strobe high
//   registers  csr_write_en/index/wdata   any edge with write enable high
//
// One item at a time. A far pair ends with a zero result; otherwise the block
// takes the horizontal distance as a square root and then goes on to either
// the line case or the search. A half-width inside the ellipse takes a square
// root and a division on the shared unit; the search forms two half-widths per
// point and one new point per iteration, the line case a single half-width.
// A new item is taken from the cycle after the strobe. Synchronous reset
// returns the controller to idle and the registers to their defaults. The
// result is shown for one cycle and cannot be held off.
// ----------------------------------------------------------------------------
module ellipsoid_overlap_depth
   import eod_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [31:0]       req_first_center_x,
   input  logic [31:0]       req_first_center_y,
   input  logic [31:0]       req_first_center_z,
   input  logic [30:0]       req_first_radius_xz,
   input  logic [30:0]       req_first_radius_y,
   input  logic              req_first_hides_lower,
   input  logic [31:0]       req_second_center_x,
   input  logic [31:0]       req_second_center_y,
   input  logic [31:0]       req_second_center_z,
   input  logic [30:0]       req_second_radius_xz,
   input  logic [30:0]       req_second_radius_y,
   input  logic              req_second_hides_lower,
   output logic              rsp_strobe,
   output logic [31:0]       rsp_overlap_depth,
   input  logic              csr_write_en,
   input  logic              csr_index,
   input  logic [TOL_W-1:0]  csr_wdata
);

   logic [TOL_W-1:0]  tol_ff;
   logic [ITER_W-1:0] cap_ff;
   cmd_type           cmd;
   status_type        status;
   logic [31:0]       in_cx [2], in_cy [2], in_cz [2];
   logic [30:0]       in_a [2], in_b [2];
   logic              in_hide [2];

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOL_RESET;
         cap_ff <= ITER_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_TOL:  tol_ff <= csr_wdata;
            CSR_ITER: cap_ff <= csr_wdata[ITER_W-1:0];
            default:  ;
         endcase
      end
   end

   // The two ellipsoids of the item, side by side.
   always_comb begin
      in_cx[0]   = req_first_center_x;
      in_cy[0]   = req_first_center_y;
      in_cz[0]   = req_first_center_z;
      in_a[0]    = req_first_radius_xz;
      in_b[0]    = req_first_radius_y;
      in_hide[0] = req_first_hides_lower;
      in_cx[1]   = req_second_center_x;
      in_cy[1]   = req_second_center_y;
      in_cz[1]   = req_second_center_z;
      in_a[1]    = req_second_radius_xz;
      in_b[1]    = req_second_radius_y;
      in_hide[1] = req_second_hides_lower;
   end

   eod_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .done   (rsp_strobe),
      .cmd    (cmd),
      .status (status)
   );

   eod_datapath u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .status   (status),
      .tol      (tol_ff),
      .iter_cap (cap_ff),
      .in_cx    (in_cx),
      .in_cy    (in_cy),
      .in_cz    (in_cz),
      .in_a     (in_a),
      .in_b     (in_b),
      .in_hide  (in_hide),
      .result   (rsp_overlap_depth)
   );

endmodule

/* rtl/core/eod_iter_unit.sv */
// ----------------------------------------------------------------------------
// eod_iter_unit: shared square root and divider
// Floor integer square root of a 64-bit value (32 steps) or quotient of a
// 62-bit value by a 31-bit divisor whose quotient fits 31 bits (31 steps),
// one result bit per clock.
// ----------------------------------------------------------------------------
module eod_iter_unit
   import eod_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  unit_mode_type mode,
   input  logic [63:0]   operand,
   input  logic [30:0]   divisor,
   output logic          done,
   output logic [31:0]   result
);

   logic [35:0]   rem_ff, rem_in;
   logic [63:0]   x_ff, x_in;
   logic [31:0]   r_ff, r_in;
   logic [5:0]    cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   unit_mode_type mode_ff, mode_in;
   logic [30:0]   dv_ff, dv_in;

   logic [35:0]   rem_sh;
   logic [35:0]   trial;

   // One step: shift in the next bits and try a subtraction.
   always_comb begin
      if (mode_ff == UNIT_SQRT) begin
         rem_sh = {rem_ff[33:0], x_ff[63:62]};
         trial  = {2'b00, r_ff, 2'b01};
      end else begin
         rem_sh = {rem_ff[34:0], x_ff[63]};
         trial  = {5'd0, dv_ff};
      end
   end

   // Load on start, then step until the count runs out.
   always_comb begin
      rem_in  = rem_ff;
      x_in    = x_ff;
      r_in    = r_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      mode_in = mode_ff;
      dv_in   = dv_ff;
      done_in = 1'b0;
      if (start) begin
         busy_in = 1'b1;
         mode_in = mode;
         dv_in   = divisor;
         r_in    = '0;
         if (mode == UNIT_SQRT) begin
            rem_in = '0;
            x_in   = operand;
            cnt_in = 6'd32;
         end else begin
            rem_in = {5'd0, operand[61:31]};
            x_in   = {operand[30:0], 33'd0};
            cnt_in = 6'd31;
         end
      end else if (busy_ff) begin
         x_in   = (mode_ff == UNIT_SQRT) ? {x_ff[61:0], 2'b00} : {x_ff[62:0], 1'b0};
         cnt_in = cnt_ff - 6'd1;
         if (rem_sh >= trial) begin
            rem_in = rem_sh - trial;
            r_in   = {r_ff[30:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            r_in   = {r_ff[30:0], 1'b0};
         end
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
         mode_ff <= UNIT_SQRT;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
         mode_ff <= mode_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      x_ff   <= x_in;
      r_ff   <= r_in;
      dv_ff  <= dv_in;
   end

   assign done   = done_ff;
   assign result = r_ff;

endmodule

/* rtl/core/eod_datapath.sv */
// ----------------------------------------------------------------------------
// eod_datapath: registers and arithmetic of the overlap computation
// Holds the item, one 32x32 multiplier with a registered product, the search
// bounds and points, and the shared square root and divider unit.
// ----------------------------------------------------------------------------
module eod_datapath
   import eod_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output status_type        status,
   input  logic [TOL_W-1:0]  tol,
   input  logic [ITER_W-1:0] iter_cap,
   input  logic [31:0]       in_cx [2],
   input  logic [31:0]       in_cy [2],
   input  logic [31:0]       in_cz [2],
   input  logic [30:0]       in_a  [2],
   input  logic [30:0]       in_b  [2],
   input  logic              in_hide [2],
   output logic [31:0]       result
);

   logic signed [31:0] cx_ff [2], cy_ff [2], cz_ff [2];
   logic [30:0]        a_ff [2], b_ff [2];
   logic               hide_ff [2];

   logic [63:0] prod_ff, prod_in;
   logic [63:0] acc_ff, acc_in;
   logic [63:0] tot_ff, tot_in;
   logic        carry_ff, carry_in;
   logic [31:0] h_ff, h_in;
   logic signed [POS_W-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic signed [POS_W-1:0] t_ff, t_in, v_ff, v_in, ey_ff, ey_in;
   logic [32:0] ft_ff, ft_in, fv_ff, fv_in, facc_ff, facc_in;
   logic [34:0] td_ff, td_in;
   logic [ITER_W-1:0] iter_ff, iter_in;
   logic [31:0] result_ff, result_in;

   logic [31:0] mul_a, mul_b;
   logic signed [32:0] dx, dy, dz, ndx, ndy, ndz;
   logic [31:0] ax, ay, az, dsum;
   logic [30:0] m0, m1;
   logic [64:0] sum65;
   logic        up, lw;
   logic signed [POS_W-1:0] lo0, lo1, hi0, hi1, wdiff;
   logic [32:0] gofs;
   logic signed [34:0] tdiff, ntdiff;
   logic signed [32:0] dyul;
   logic [33:0] fsum;
   logic signed [34:0] fdiff;

   logic          u_start, u_done;
   unit_mode_type u_mode;
   logic [63:0]   u_opnd;
   logic [31:0]   u_res;

   // Distances between the centres and the bounding radius sum.
   always_comb begin
      dx   = {cx_ff[0][31], cx_ff[0]} - {cx_ff[1][31], cx_ff[1]};
      dy   = {cy_ff[0][31], cy_ff[0]} - {cy_ff[1][31], cy_ff[1]};
      dz   = {cz_ff[0][31], cz_ff[0]} - {cz_ff[1][31], cz_ff[1]};
      ndx  = -dx;
      ndy  = -dy;
      ndz  = -dz;
      ax   = dx[32] ? ndx[31:0] : dx[31:0];
      ay   = dy[32] ? ndy[31:0] : dy[31:0];
      az   = dz[32] ? ndz[31:0] : dz[31:0];
      m0   = (a_ff[0] > b_ff[0]) ? a_ff[0] : b_ff[0];
      m1   = (a_ff[1] > b_ff[1]) ? a_ff[1] : b_ff[1];
      dsum = {1'b0, m0} + {1'b0, m1};
      up   = (cy_ff[0] < cy_ff[1]);
      lw   = ~up;
      dyul = {cy_ff[up][31], cy_ff[up]} - {cy_ff[lw][31], cy_ff[lw]};
   end

   // Shared height span of the two ellipsoids and the golden offset.
   always_comb begin
      lo0   = {{2{cy_ff[0][31]}}, cy_ff[0]} - {3'd0, b_ff[0]};
      lo1   = {{2{cy_ff[1][31]}}, cy_ff[1]} - {3'd0, b_ff[1]};
      hi0   = {{2{cy_ff[0][31]}}, cy_ff[0]} + {3'd0, b_ff[0]};
      hi1   = {{2{cy_ff[1][31]}}, cy_ff[1]} + {3'd0, b_ff[1]};
      wdiff = hi_ff - lo_ff;
      gofs  = {1'b0, prod_ff[63:32]}
            + (wdiff[32] ? {1'b0, (cmd.sel_v ? GOLD_Q32 : GOLD_C_Q32)} : 33'd0);
      tdiff  = {ey_ff[POS_W-1], ey_ff} - {{3{cy_ff[cmd.ek][31]}}, cy_ff[cmd.ek]};
      ntdiff = -tdiff;
   end

   // Final depth before clamping.
   always_comb begin
      fsum = {1'b0, ft_ff} + {1'b0, fv_ff};
      if (cmd.op == OP_FINAL_H)
         fdiff = {4'd0, a_ff[up]} + {2'd0, facc_ff} - {3'd0, h_ff};
      else
         fdiff = {2'd0, fsum[33:1]} - {3'd0, h_ff};
   end

   // Multiplier operand selection.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (cmd.op)
         OP_MX: begin
            mul_a = ax;
            mul_b = ax;
         end
         OP_MZ: begin
            mul_a = az;
            mul_b = az;
         end
         OP_MY: begin
            mul_a = ay;
            mul_b = ay;
         end
         OP_MD: begin
            mul_a = dsum;
            mul_b = dsum;
         end
         OP_GMUL: begin
            mul_a = wdiff[31:0];
            mul_b = cmd.sel_v ? GOLD_Q32 : GOLD_C_Q32;
         end
         OP_HW_BB: begin
            mul_a = {1'b0, b_ff[cmd.ek]};
            mul_b = {1'b0, b_ff[cmd.ek]};
         end
         OP_HW_TT: begin
            mul_a = td_ff[31:0];
            mul_b = td_ff[31:0];
         end
         OP_HW_AS: begin
            mul_a = {1'b0, a_ff[cmd.ek]};
            mul_b = u_res;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Register updates per operation.
   always_comb begin
      prod_in   = {32'd0, mul_a} * {32'd0, mul_b};
      acc_in    = acc_ff;
      tot_in    = tot_ff;
      carry_in  = carry_ff;
      h_in      = h_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      t_in      = t_ff;
      v_in      = v_ff;
      ey_in     = ey_ff;
      ft_in     = ft_ff;
      fv_in     = fv_ff;
      facc_in   = facc_ff;
      td_in     = td_ff;
      iter_in   = iter_ff;
      result_in = result_ff;
      sum65     = {1'b0, acc_ff} + {1'b0, prod_ff};
      unique case (cmd.op)
         OP_LOAD: begin
            iter_in  = '0;
            carry_in = 1'b0;
         end
         OP_MZ: acc_in = prod_ff;
         OP_MY: begin
            acc_in   = sum65[63:0];
            carry_in = sum65[64];
         end
         OP_MD: begin
            tot_in   = sum65[63:0];
            carry_in = carry_ff | sum65[64];
         end
         OP_H_END: begin
            h_in  = u_res;
            lo_in = (lo0 > lo1) ? lo0 : lo1;
            hi_in = (hi0 < hi1) ? hi0 : hi1;
         end
         OP_GADD: begin
            if (cmd.sel_v)
               v_in = lo_ff + {1'b0, gofs};
            else
               t_in = lo_ff + {1'b0, gofs};
         end
         OP_EV_SET: begin
            facc_in = '0;
            if (cmd.hide)
               ey_in = {{2{cy_ff[up][31]}}, cy_ff[up]};
            else
               ey_in = cmd.sel_v ? v_ff : t_ff;
         end
         OP_HW_T: td_in = tdiff[34] ? ntdiff : tdiff;
         OP_HW_TT: acc_in = prod_ff;
         OP_HW_ACC: facc_in = facc_ff + {1'b0, u_res};
         OP_STORE: begin
            if (cmd.sel_v)
               fv_in = facc_ff;
            else
               ft_in = facc_ff;
         end
         OP_MOVE: begin
            iter_in = iter_ff + 1'b1;
            if (ft_ff < fv_ff) begin
               lo_in = t_ff;
               t_in  = v_ff;
               ft_in = fv_ff;
            end else begin
               hi_in = v_ff;
               v_in  = t_ff;
               fv_in = ft_ff;
            end
         end
         OP_FINAL_S, OP_FINAL_H: begin
            if (fdiff[34])
               result_in = '0;
            else if (fdiff[33:32] != 2'b00)
               result_in = '1;
            else
               result_in = fdiff[31:0];
         end
         OP_ZERO: result_in = '0;
         default: ;
      endcase
   end

   // Item capture, with a zero radius taken as one step.
   always_ff @(posedge clock) begin
      if (cmd.op == OP_LOAD) begin
         for (int k = 0; k < 2; k++) begin
            cx_ff[k]   <= in_cx[k];
            cy_ff[k]   <= in_cy[k];
            cz_ff[k]   <= in_cz[k];
            a_ff[k]    <= (in_a[k] == '0) ? 31'd1 : in_a[k];
            b_ff[k]    <= (in_b[k] == '0) ? 31'd1 : in_b[k];
            hide_ff[k] <= in_hide[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff   <= prod_in;
      acc_ff    <= acc_in;
      tot_ff    <= tot_in;
      carry_ff  <= carry_in;
      h_ff      <= h_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      t_ff      <= t_in;
      v_ff      <= v_in;
      ey_ff     <= ey_in;
      ft_ff     <= ft_in;
      fv_ff     <= fv_in;
      facc_ff   <= facc_in;
      td_ff     <= td_in;
      iter_ff   <= iter_in;
      result_ff <= result_in;
   end

   // Square root and divide requests.
   always_comb begin
      u_start = (cmd.op == OP_SQH_GO) || (cmd.op == OP_HW_SQ) || (cmd.op == OP_HW_DIV);
      u_mode  = (cmd.op == OP_HW_DIV) ? UNIT_DIV : UNIT_SQRT;
      if (cmd.op == OP_HW_SQ)
         u_opnd = acc_ff - prod_ff;
      else if (cmd.op == OP_HW_DIV)
         u_opnd = prod_ff;
      else
         u_opnd = acc_ff;
   end

   eod_iter_unit u_iter (
      .clock   (clock),
      .reset   (reset),
      .start   (u_start),
      .mode    (u_mode),
      .operand (u_opnd),
      .divisor (b_ff[cmd.ek]),
      .done    (u_done),
      .result  (u_res)
   );

   // Status back to the controller.
   always_comb begin
      status.far        = carry_ff || (tot_ff > prod_ff);
      status.up         = up;
      status.hide_up    = hide_ff[up];
      status.dy_gt      = (dyul > {2'b00, b_ff[lw]});
      status.span_empty = (lo_ff > hi_ff);
      status.hw_zero    = (td_ff > {4'd0, b_ff[cmd.ek]});
      status.unit_done  = u_done;
      status.ft_lt_fv   = (ft_ff < fv_ff);
      status.stop       = ($unsigned(wdiff) <= {{(POS_W-TOL_W){1'b0}}, tol})
                        || (iter_ff == iter_cap);
   end

   assign result = result_ff;

endmodule

/* rtl/core/eod_ctrl.sv */
// ----------------------------------------------------------------------------
// eod_ctrl: sequencing state machine
// Steps the datapath through the sphere test, the horizontal distance, the
// line case or the golden-section search, and the final clamp.
// ----------------------------------------------------------------------------
module eod_ctrl
   import eod_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   output logic       done,
   output cmd_type    cmd,
   input  status_type status
);

   typedef enum logic [27:0] {
      ST_IDLE   = 28'h0000001,
      ST_MX     = 28'h0000002,
      ST_MZ     = 28'h0000004,
      ST_MY     = 28'h0000008,
      ST_MD     = 28'h0000010,
      ST_MC     = 28'h0000020,
      ST_SQH    = 28'h0000040,
      ST_SQHW   = 28'h0000080,
      ST_HEND   = 28'h0000100,
      ST_BRANCH = 28'h0000200,
      ST_GMUL   = 28'h0000400,
      ST_GADD   = 28'h0000800,
      ST_EVSET  = 28'h0001000,
      ST_HWT    = 28'h0002000,
      ST_HWBB   = 28'h0004000,
      ST_HWTT   = 28'h0008000,
      ST_HWSQ   = 28'h0010000,
      ST_HWSQW  = 28'h0020000,
      ST_HWAS   = 28'h0040000,
      ST_HWDIV  = 28'h0080000,
      ST_HWDIVW = 28'h0100000,
      ST_HWACC  = 28'h0200000,
      ST_STORE  = 28'h0400000,
      ST_CHECK  = 28'h0800000,
      ST_MOVE   = 28'h1000000,
      ST_FINAL  = 28'h2000000,
      ST_ZERO   = 28'h4000000,
      ST_DONE   = 28'h8000000
   } state_type;

   typedef enum logic [1:0] {
      CTX_INIT_T,
      CTX_INIT_V,
      CTX_LOOP,
      CTX_HIDE
   } ctx_type;

   state_type state_ff, state_in;
   ctx_type   ctx_ff, ctx_in;
   logic      gsel_ff, gsel_in;
   logic      ek_ff, ek_in;
   state_type after_k;
   logic      is_hide;

   assign is_hide = (ctx_ff == CTX_HIDE);

   // Second ellipsoid next, unless the line case needs only one.
   always_comb begin
      if (!is_hide && !ek_ff)
         after_k = ST_HWT;
      else
         after_k = ST_STORE;
   end

   // Next state and the command for this cycle.
   always_comb begin
      state_in  = state_ff;
      ctx_in    = ctx_ff;
      gsel_in   = gsel_ff;
      ek_in     = ek_ff;
      cmd.op    = OP_NOP;
      cmd.sel_v = gsel_ff;
      cmd.hide  = is_hide;
      cmd.ek    = ek_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.op   = OP_LOAD;
               state_in = ST_MX;
            end
         end
         ST_MX: begin
            cmd.op   = OP_MX;
            state_in = ST_MZ;
         end
         ST_MZ: begin
            cmd.op   = OP_MZ;
            state_in = ST_MY;
         end
         ST_MY: begin
            cmd.op   = OP_MY;
            state_in = ST_MD;
         end
         ST_MD: begin
            cmd.op   = OP_MD;
            state_in = ST_MC;
         end
         ST_MC: state_in = status.far ? ST_ZERO : ST_SQH;
         ST_SQH: begin
            cmd.op   = OP_SQH_GO;
            state_in = ST_SQHW;
         end
         ST_SQHW: if (status.unit_done) state_in = ST_HEND;
         ST_HEND: begin
            cmd.op   = OP_H_END;
            state_in = ST_BRANCH;
         end
         ST_BRANCH: begin
            gsel_in = 1'b0;
            if (status.hide_up) begin
               ctx_in   = CTX_HIDE;
               state_in = status.dy_gt ? ST_ZERO : ST_EVSET;
            end else begin
               ctx_in   = CTX_INIT_T;
               state_in = status.span_empty ? ST_ZERO : ST_GMUL;
            end
         end
         ST_GMUL: begin
            cmd.op   = OP_GMUL;
            state_in = ST_GADD;
         end
         ST_GADD: begin
            cmd.op   = OP_GADD;
            state_in = ST_EVSET;
         end
         ST_EVSET: begin
            cmd.op   = OP_EV_SET;
            ek_in    = is_hide ? ~status.up : 1'b0;
            state_in = ST_HWT;
         end
         ST_HWT: begin
            cmd.op   = OP_HW_T;
            state_in = ST_HWBB;
         end
         ST_HWBB: begin
            cmd.op = OP_HW_BB;
            if (status.hw_zero) begin
               ek_in    = 1'b1;
               state_in = after_k;
            end else begin
               state_in = ST_HWTT;
            end
         end
         ST_HWTT: begin
            cmd.op   = OP_HW_TT;
            state_in = ST_HWSQ;
         end
         ST_HWSQ: begin
            cmd.op   = OP_HW_SQ;
            state_in = ST_HWSQW;
         end
         ST_HWSQW: if (status.unit_done) state_in = ST_HWAS;
         ST_HWAS: begin
            cmd.op   = OP_HW_AS;
            state_in = ST_HWDIV;
         end
         ST_HWDIV: begin
            cmd.op   = OP_HW_DIV;
            state_in = ST_HWDIVW;
         end
         ST_HWDIVW: if (status.unit_done) state_in = ST_HWACC;
         ST_HWACC: begin
            cmd.op   = OP_HW_ACC;
            ek_in    = 1'b1;
            state_in = after_k;
         end
         ST_STORE: begin
            cmd.op = OP_STORE;
            priority case (ctx_ff)
               CTX_HIDE:   state_in = ST_FINAL;
               CTX_INIT_T: begin
                  ctx_in   = CTX_INIT_V;
                  gsel_in  = 1'b1;
                  state_in = ST_GMUL;
               end
               default:    state_in = ST_CHECK;
            endcase
         end
         ST_CHECK: state_in = status.stop ? ST_FINAL : ST_MOVE;
         ST_MOVE: begin
            cmd.op   = OP_MOVE;
            ctx_in   = CTX_LOOP;
            gsel_in  = status.ft_lt_fv;
            state_in = ST_GMUL;
         end
         ST_FINAL: begin
            cmd.op   = is_hide ? OP_FINAL_H : OP_FINAL_S;
            state_in = ST_DONE;
         end
         ST_ZERO: begin
            cmd.op   = OP_ZERO;
            state_in = ST_DONE;
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ctx_ff   <= CTX_INIT_T;
         gsel_ff  <= 1'b0;
         ek_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         ctx_ff   <= ctx_in;
         gsel_ff  <= gsel_in;
         ek_ff    <= ek_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);
   assign done = (state_ff == ST_DONE);

endmodule

/* rtl/core/eod_checker.sv */
// ----------------------------------------------------------------------------
// eod_checker: port-level checks of the overlap block
// Watches the command handshake and the result strobe over time.
// ----------------------------------------------------------------------------
module eod_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_strobe
);

   // An accepted item makes the block busy.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted item did not make the block busy");

   // A result only appears while an item is in flight.
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result strobe while idle");

   // One result per item: the strobe ends the item.
   a_strobe_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !busy && !rsp_strobe)
      else $error("block still busy after the result");

   // An item never finishes in the cycle after it is taken.
   a_no_instant: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> !rsp_strobe)
      else $error("result strobe straight after acceptance");

endmodule

bind ellipsoid_overlap_depth eod_checker u_eod_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe)
);

/* sim/ellipsoid_overlap_depth_tb.sv */
// ----------------------------------------------------------------------------
// ellipsoid_overlap_depth_tb: self-checking bench for the overlap depth block
// Drives directed and random ellipsoid pairs through the command port under
// several search settings. A predictor computes the expected depth of every
// accepted item and a scoreboard compares it with each strobed result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module ellipsoid_overlap_depth_tb
   import eod_pkg::*;
();

   localparam int unsigned WATCHDOG_LIMIT = 200000;
   localparam logic [63:0] GOLD_U   = 64'd2654435769;
   localparam logic [63:0] GOLD_C_U = 64'd1640531527;

   // One ellipsoid of an item.
   typedef struct {
      logic [31:0] cx, cy, cz;
      logic [30:0] rxz, ry;
      logic        hide;
   } shape_type;

   // Search settings held by the predictor.
   logic [TOL_W-1:0]  tol_setting;
   logic [ITER_W-1:0] iter_setting;

   function automatic logic [63:0] floor_sqrt(logic [63:0] v);
      logic [63:0] r, bit_q;
      r = 0;
      bit_q = 64'd1 << 62;
      while (bit_q > v) bit_q = bit_q >> 2;
      while (bit_q != 0) begin
         if (v >= r + bit_q) begin
            v = v - (r + bit_q);
            r = (r >> 1) + bit_q;
         end else begin
            r = r >> 1;
         end
         bit_q = bit_q >> 2;
      end
      return r;
   endfunction

   function automatic longint half_width(logic [63:0] a, logic [63:0] b, longint c,
                                         longint y);
      longint d;
      logic [63:0] t, s;
      d = y - c;
      t = (d < 0) ? -d : d;
      if (t > b) return 0;
      s = floor_sqrt(b * b - t * t);
      return longint'((a * s) / b);
   endfunction

   // Expected overlap depth of one pair.
   function automatic logic [31:0] overlap_depth(shape_type e0, shape_type e1);
      longint cx[2], cy[2], cz[2], h, lo, hi, t, v, ft, fv, res, lo0, lo1, hi0, hi1;
      logic [63:0] rxz[2], ry[2], d, ax, ay, az, hsq, tot, w, dy, s, it;
      logic carry;
      int u, l;
      shape_type e[2];
      e[0] = e0; e[1] = e1;
      for (int k = 0; k < 2; k++) begin
         cx[k] = longint'(signed'(e[k].cx));
         cy[k] = longint'(signed'(e[k].cy));
         cz[k] = longint'(signed'(e[k].cz));
         rxz[k] = (e[k].rxz == 0) ? 64'd1 : 64'(e[k].rxz);
         ry[k] = (e[k].ry == 0) ? 64'd1 : 64'(e[k].ry);
      end
      d = ((rxz[0] > ry[0]) ? rxz[0] : ry[0]) + ((rxz[1] > ry[1]) ? rxz[1] : ry[1]);
      ax = (cx[0] > cx[1]) ? cx[0] - cx[1] : cx[1] - cx[0];
      ay = (cy[0] > cy[1]) ? cy[0] - cy[1] : cy[1] - cy[0];
      az = (cz[0] > cz[1]) ? cz[0] - cz[1] : cz[1] - cz[0];
      hsq = ax * ax + az * az;
      carry = hsq < ax * ax;
      tot = hsq + ay * ay;
      if (tot < hsq) carry = 1;
      if (carry || tot > d * d) return 0;
      u = (cy[0] < cy[1]) ? 1 : 0;
      l = 1 - u;
      h = longint'(floor_sqrt(hsq));
      if (e[u].hide) begin
         dy = cy[u] - cy[l];
         if (dy > ry[l]) return 0;
         s = floor_sqrt(ry[l] * ry[l] - dy * dy);
         res = longint'(rxz[u]) + longint'((rxz[l] * s) / ry[l]) - h;
      end else begin
         lo0 = cy[0] - longint'(ry[0]); lo1 = cy[1] - longint'(ry[1]);
         hi0 = cy[0] + longint'(ry[0]); hi1 = cy[1] + longint'(ry[1]);
         lo = (lo0 > lo1) ? lo0 : lo1;
         hi = (hi0 < hi1) ? hi0 : hi1;
         if (lo > hi) return 0;
         w = hi - lo;
         t = lo + longint'((w * GOLD_C_U) >> 32);
         v = lo + longint'((w * GOLD_U) >> 32);
         ft = half_width(rxz[0], ry[0], cy[0], t) + half_width(rxz[1], ry[1], cy[1], t);
         fv = half_width(rxz[0], ry[0], cy[0], v) + half_width(rxz[1], ry[1], cy[1], v);
         it = 0;
         while (64'(hi - lo) > 64'(tol_setting)) begin
            if (it == 64'(iter_setting)) break;
            it++;
            if (ft < fv) begin
               lo = t; t = v; ft = fv;
               w = hi - lo;
               v = lo + longint'((w * GOLD_U) >> 32);
               fv = half_width(rxz[0], ry[0], cy[0], v)
                    + half_width(rxz[1], ry[1], cy[1], v);
            end else begin
               hi = v; v = t; fv = ft;
               w = hi - lo;
               t = lo + longint'((w * GOLD_C_U) >> 32);
               ft = half_width(rxz[0], ry[0], cy[0], t)
                    + half_width(rxz[1], ry[1], cy[1], t);
            end
         end
         res = (ft + fv) / 2 - h;
      end
      if (res < 0) return 0;
      if (res > 64'hFFFFFFFF) return 32'hFFFFFFFF;
      return res[31:0];
   endfunction

   // Holds expected depths in order and checks strobed results against them.
   class depth_scoreboard_type;
      logic [31:0] pending[$];
      int errors;

      function void note_item(shape_type e0, shape_type e1);
         pending.push_back(overlap_depth(e0, e1));
      endfunction

      function void check_depth(logic [31:0] got);
         logic [31:0] want;
         if (pending.size() == 0) begin
            $error("unexpected result: overlap_depth actual %0d", got);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got !== want) begin
            $error("overlap_depth mismatch: expected %0d actual %0d", want, got);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic [31:0] req_first_center_x = 0, req_first_center_y = 0, req_first_center_z = 0;
   logic [30:0] req_first_radius_xz = 1, req_first_radius_y = 1;
   logic        req_first_hides_lower = 0;
   logic [31:0] req_second_center_x = 0, req_second_center_y = 0, req_second_center_z = 0;
   logic [30:0] req_second_radius_xz = 1, req_second_radius_y = 1;
   logic        req_second_hides_lower = 0;
   logic        rsp_strobe;
   logic [31:0] rsp_overlap_depth;
   logic        csr_write_en = 0;
   logic        csr_index = CSR_TOL;
   logic [TOL_W-1:0] csr_wdata = 0;

   depth_scoreboard_type board = new();
   int unsigned quiet_cycles = 0;
   bit calm = 0;

   always #1 clock = ~clock;

   ellipsoid_overlap_depth DUT (.*);

   // Check results and keep the watchdog.
   always @(posedge clock) begin
      if (!reset && rsp_strobe) board.check_depth(rsp_overlap_depth);
      if ((start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("ellipsoid_overlap_depth_tb: FAIL");
            $finish;
         end
      end
   end

   task automatic write_reg(logic idx, logic [TOL_W-1:0] val);
      csr_write_en <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_write_en <= 0;
      if (idx == CSR_TOL) tol_setting = val;
      else iter_setting = val[ITER_W-1:0];
   endtask

   // Present one item and hold it until accepted.
   task automatic send_pair(shape_type e0, shape_type e1);
      if (!calm && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 19)) @(posedge clock);
      req_first_center_x <= e0.cx; req_first_center_y <= e0.cy;
      req_first_center_z <= e0.cz; req_first_radius_xz <= e0.rxz;
      req_first_radius_y <= e0.ry; req_first_hides_lower <= e0.hide;
      req_second_center_x <= e1.cx; req_second_center_y <= e1.cy;
      req_second_center_z <= e1.cz; req_second_radius_xz <= e1.rxz;
      req_second_radius_y <= e1.ry; req_second_hides_lower <= e1.hide;
      start <= 1;
      @(posedge clock);
      while (busy) @(posedge clock);
      board.note_item(e0, e1);
      start <= 0;
      @(posedge clock);
   endtask

   task automatic drain;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic shape_type random_shape(int kind);
      shape_type e;
      logic [31:0] span;
      case (kind)
         0: begin
            // Full range of every field.
            e.cx = $urandom; e.cy = $urandom; e.cz = $urandom;
            e.rxz = 31'($urandom); e.ry = 31'($urandom);
         end
         default: begin
            // Nearby pairs so that the search is actually reached.
            span = 32'd1 << $urandom_range(4, 26);
            e.cx = $urandom_range(0, span) - span / 2;
            e.cy = $urandom_range(0, span) - span / 2;
            e.cz = $urandom_range(0, span) - span / 2;
            e.rxz = 31'($urandom_range(0, span));
            e.ry = 31'($urandom_range(0, span));
         end
      endcase
      e.hide = ($urandom_range(0, 3) == 0);
      return e;
   endfunction

   function automatic shape_type make_shape(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                            logic [30:0] a, logic [30:0] b, logic hd);
      shape_type e;
      e.cx = x; e.cy = y; e.cz = z; e.rxz = a; e.ry = b; e.hide = hd;
      return e;
   endfunction

   initial begin
      shape_type p, q;
      tol_setting = TOL_RESET;
      iter_setting = ITER_RESET;
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed pairs under the reset settings.
      send_pair(make_shape(0, 0, 0, 0, 0, 0), make_shape(0, 0, 0, 0, 0, 0));
      send_pair(make_shape(0, 0, 0, 65536, 65536, 0), make_shape(0, 0, 0, 65536, 65536, 0));
      send_pair(make_shape(0, 0, 0, 65536, 65536, 1), make_shape(0, 0, 0, 65536, 65536, 1));
      send_pair(make_shape(1000, 0, 2000, 65536, 32768, 0),
                make_shape(0, 0, 0, 98304, 65536, 0));
      send_pair(make_shape(0, 50000, 0, 65536, 65536, 1), make_shape(30000, 0, 0, 65536, 65536, 0));
      send_pair(make_shape(0, 0, 0, 65536, 65536, 0), make_shape(0, 60000, 0, 65536, 65536, 1));
      send_pair(make_shape(0, 200000, 0, 65536, 65536, 1), make_shape(0, 0, 0, 300000, 65536, 0));
      send_pair(make_shape(0, 0, 0, 65536, 10, 0), make_shape(10000, 0, 0, 65536, 10, 0));
      send_pair(make_shape(32'h80000000, 32'h80000000, 32'h80000000, 31'h7FFFFFFF,
                           31'h7FFFFFFF, 1),
                make_shape(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 31'h7FFFFFFF,
                           31'h7FFFFFFF, 1));
      send_pair(make_shape(0, 0, 0, 31'h7FFFFFFF, 31'h7FFFFFFF, 0),
                make_shape(0, 0, 0, 31'h7FFFFFFF, 31'h7FFFFFFF, 0));
      send_pair(make_shape(0, 0, 0, 31'h7FFFFFFF, 31'h7FFFFFFF, 1),
                make_shape(0, 0, 0, 31'h7FFFFFFF, 31'h7FFFFFFF, 0));
      send_pair(make_shape(0, 0, 0, 65536, 65536, 0), make_shape(500000, 0, 0, 65536, 65536, 0));
      send_pair(make_shape(0, 0, 0, 65536, 100, 0), make_shape(100, 1000, 0, 65536, 100, 0));
      drain();

      // Several search settings, the extremes among them.
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin write_reg(CSR_TOL, 17'd0); write_reg(CSR_ITER, 17'd1); end
            1: begin write_reg(CSR_TOL, 17'h1FFFF); write_reg(CSR_ITER, 17'h7F); end
            2: begin write_reg(CSR_TOL, 17'd1); write_reg(CSR_ITER, 17'd64); end
            3: begin write_reg(CSR_TOL, 17'd65536); write_reg(CSR_ITER, 17'd0); end
            4: begin write_reg(CSR_TOL, 17'd66); write_reg(CSR_ITER, 17'd4); end
            default: begin
               write_reg(CSR_TOL, 17'($urandom_range(1, 4000)));
               write_reg(CSR_ITER, 17'($urandom_range(1, 12)));
            end
         endcase
         calm = (phase == 5);
         for (int n = 0; n < ((phase == 1 || phase == 2) ? 40 : 270); n++) begin
            int kind;
            kind = ($urandom_range(0, 9) == 0) ? 0 : 1;
            p = random_shape(kind);
            q = random_shape(kind);
            send_pair(p, q);
         end
         drain();
      end

      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("ellipsoid_overlap_depth_tb: PASS");
      end else begin
         $display("ellipsoid_overlap_depth_tb: FAIL");
      end
      $finish;
   end

endmodule
